[rtl/sorted_priority_queue_by_tag_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Implication checks on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_BY_TAG_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_BY_TAG_ASSERT_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
        else $error("spq assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
        else $error("spq assertion failed");

`endif

[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Widths, codes and word types shared by the priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int KIND_W   = 3;
    localparam int TAG_W    = 16;
    localparam int PRIO_W   = 32;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam int DEF_CAPACITY = 16;
    localparam int DEF_TAG_BITS = 16;

    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [TAG_W-1:0]         tag;
        logic signed [PRIO_W-1:0] prio;
        logic [DATA_W-1:0]        payload;
    } spq_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [TAG_W-1:0]         out_tag;
        logic signed [PRIO_W-1:0] out_prio;
        logic [DATA_W-1:0]        out_payload;
        logic [OCC_W-1:0]         occupancy;
    } spq_out_t;

    typedef struct packed {
        logic [TAG_W-1:0]         tag;
        logic signed [PRIO_W-1:0] prio;
        logic [DATA_W-1:0]        payload;
    } entry_t;

    // broadcast to every cell
    typedef struct packed {
        logic [1:0]               op;
        logic                     any_tag;   // match every occupied cell (head ops)
        logic [TAG_W-1:0]         key_tag;
        logic signed [PRIO_W-1:0] key_prio;
        entry_t                   ent;
    } cell_ctl_t;

endpackage

[rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: compares against the broadcast key and
// loads from itself, its left or right neighbor, or the new entry.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic              aclk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic              occ,
    input  logic              ge_in,
    input  logic              found_in,
    input  spq_pkg::entry_t   left_ent,
    input  spq_pkg::entry_t   right_ent,
    output spq_pkg::entry_t   ent,
    output logic              ge_out,
    output logic              found_out,
    output spq_pkg::entry_t   hit_ent
);
    import spq_pkg::*;

    entry_t ent_reg;
    logic   match;

    assign ent = ent_reg;

    // slots past the fill level count as "greater", so the insert point is
    // the first slot at or above the key
    assign ge_out    = ge_in || !occ || ($signed(ent_reg.prio) >= $signed(ctl.key_prio));
    assign match     = occ && (ctl.any_tag || (ent_reg.tag == ctl.key_tag));
    assign found_out = found_in || match;
    assign hit_ent   = (match && !found_in) ? ent_reg : '0;

    always_ff @(posedge aclk) begin
        case (ctl.op)
            OP_INSERT: begin
                if (ge_in) begin
                    ent_reg <= left_ent;
                end else if (ge_out) begin
                    ent_reg <= ctl.ent;
                end
            end
            OP_REMOVE: begin
                if (found_out) begin
                    ent_reg <= right_ent;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/sorted_priority_queue_by_tag.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_by_tag
// Bounded priority queue kept in ascending priority order in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command word (kind, tag, prio, payload); m_* returns one
//   result word per command (status, entry fields, occupancy after it).
//   Every cell compares against the command in the cycle it is accepted and
//   shifts toward or away from the head at that same edge, so the result word
//   is registered at the edge that accepts the command. Set-priority adds a
//   reinsertion pass through the row before its result is registered.
//   The result register must be emptied before the next command is taken,
//   so a stalled receiver holds s_ready low; s_ready is also low during the
//   set-priority reinsertion pass.
//   Insert into a full queue is dropped with status full; a miss or an empty
//   queue returns status not found with zeroed entry fields.
//   Reset empties the queue (fill count to zero) and drops any pending
//   result; cell contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_by_tag #(
    parameter int CAPACITY = spq_pkg::DEF_CAPACITY,
    parameter int TAG_BITS = spq_pkg::DEF_TAG_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  spq_pkg::spq_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output spq_pkg::spq_out_t m_data
);
    import spq_pkg::*;

    localparam int CntW    = $clog2(CAPACITY + 1);
    localparam int TagKeep = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam logic [TAG_W-1:0] TagMask = {TAG_W{1'b1}} >> (TAG_W - TagKeep);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_REINS = 1'b1;

    logic            state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            m_valid_reg, m_valid_next;
    spq_out_t        out_reg, out_next;
    entry_t          hold_reg, hold_next;

    cell_ctl_t       ctl;
    logic            s_fire, full;
    logic            res_load;
    entry_t          ent [CAPACITY];
    entry_t          hit [CAPACITY];
    logic            ge    [CAPACITY+1];
    logic            found [CAPACITY+1];
    entry_t          hit_any;
    logic            found_any;

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign full    = (count_reg == CntW'(CAPACITY));
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign ge[0]     = 1'b0;
    assign found[0]  = 1'b0;
    assign found_any = found[CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            entry_t left_w, right_w;
            logic   occ_w;
            if (gi == 0) begin : g_first
                assign left_w = ctl.ent;
            end else begin : g_mid
                assign left_w = ent[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_w = ent[gi];
            end else begin : g_inner
                assign right_w = ent[gi+1];
            end
            assign occ_w = (CntW'(gi) < count_reg);
            spq_cell u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .occ       (occ_w),
                .ge_in     (ge[gi]),
                .found_in  (found[gi]),
                .left_ent  (left_w),
                .right_ent (right_w),
                .ent       (ent[gi]),
                .ge_out    (ge[gi+1]),
                .found_out (found[gi+1]),
                .hit_ent   (hit[gi])
            );
        end
    endgenerate

    // at most one cell reports a hit
    always_comb begin
        hit_any = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_any = hit_any | hit[i];
        end
    end

    always_comb begin
        ctl.op          = OP_HOLD;
        ctl.any_tag     = (s_data.kind == KIND_POP) || (s_data.kind == KIND_PEEK);
        ctl.key_tag     = s_data.tag & TagMask;
        ctl.key_prio    = s_data.prio;
        ctl.ent.tag     = s_data.tag & TagMask;
        ctl.ent.prio    = s_data.prio;
        ctl.ent.payload = s_data.payload;
        if (state_reg == ST_REINS) begin
            ctl.op       = OP_INSERT;
            ctl.key_prio = hold_reg.prio;
            ctl.ent      = hold_reg;
        end else if (s_fire) begin
            unique case (s_data.kind) inside
                KIND_INSERT: begin
                    if (!full) begin
                        ctl.op = OP_INSERT;
                    end
                end
                KIND_REMOVE, KIND_SET, KIND_POP: begin
                    ctl.op = OP_REMOVE;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        hold_next    = hold_reg;
        out_next     = out_reg;
        res_load     = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_REINS: begin
                count_next           = count_reg + 1'b1;
                res_load             = 1'b1;
                out_next.status      = STATUS_OK;
                out_next.out_tag     = hold_reg.tag;
                out_next.out_prio    = hold_reg.prio;
                out_next.out_payload = hold_reg.payload;
                state_next           = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_fire) begin
                    res_load             = 1'b1;
                    out_next.status      = STATUS_NOTFOUND;
                    out_next.out_tag     = '0;
                    out_next.out_prio    = '0;
                    out_next.out_payload = '0;
                    unique case (s_data.kind) inside
                        KIND_INSERT: begin
                            if (full) begin
                                out_next.status = STATUS_FULL;
                            end else begin
                                out_next.status = STATUS_OK;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        KIND_REMOVE, KIND_POP: begin
                            if (found_any) begin
                                out_next.status      = STATUS_OK;
                                out_next.out_tag     = hit_any.tag;
                                out_next.out_prio    = hit_any.prio;
                                out_next.out_payload = hit_any.payload;
                                count_next           = count_reg - 1'b1;
                            end
                        end
                        KIND_PEEK, KIND_LOOKUP: begin
                            if (found_any) begin
                                out_next.status      = STATUS_OK;
                                out_next.out_tag     = hit_any.tag;
                                out_next.out_prio    = hit_any.prio;
                                out_next.out_payload = hit_any.payload;
                            end
                        end
                        KIND_SET: begin
                            if (found_any) begin
                                // entry is out of the row now; put it back next cycle
                                count_next        = count_reg - 1'b1;
                                hold_next.tag     = hit_any.tag;
                                hold_next.prio    = s_data.prio;
                                hold_next.payload = hit_any.payload;
                                state_next        = ST_REINS;
                                res_load          = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        if (res_load) begin
            m_valid_next       = 1'b1;
            out_next.occupancy = OCC_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

`include "sorted_priority_queue_by_tag_assert.svh"

    `SPQ_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CntW'(CAPACITY))
    `SPQ_ASSERT_NEXT(a_insert_grows, aclk, aresetn, s_fire && (s_data.kind == KIND_INSERT) && !full, count_reg == $past(count_reg) + 1'b1)
    `SPQ_ASSERT_NEXT(a_reins_result, aclk, aresetn, state_reg == ST_REINS, m_valid_reg && (state_reg == ST_IDLE))
    `SPQ_ASSERT_NOW(a_occ_match, aclk, aresetn, m_valid_reg, out_reg.occupancy == OCC_W'(count_reg))

endmodule
